FILE: rtl/csq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex sample quantizer package
// Register indexes, fixed field widths and reset values shared by the block.
// ----------------------------------------------------------------------------
package csq_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_BITS  = 2'd0,
    CFG_UPPER_LIMIT = 2'd1,
    CFG_LOWER_LIMIT = 2'd2
  } cfg_idx_t;

  // Fixed widths of the level-bits register and of the bin index fields.
  localparam int LEVEL_BITS_W = 4;
  localparam int BIN_W        = 8;

  // Reset values of the configuration registers.
  localparam int LEVEL_BITS_RESET  = 1;
  localparam int UPPER_LIMIT_RESET = 4096;
  localparam int LOWER_LIMIT_RESET = -4096;

endpackage

FILE: rtl/csq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel interface
// Valid/ready channel carrying one complex sample per transaction.
// ----------------------------------------------------------------------------
interface csq_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_real;
  logic signed [SAMPLE_WIDTH-1:0] sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

FILE: rtl/csq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantized result channel interface
// Valid/ready channel carrying both quantized levels and bin indices.
// ----------------------------------------------------------------------------
interface csq_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  import csq_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] level_real;
  logic signed [SAMPLE_WIDTH-1:0] level_imag;
  logic        [BIN_W-1:0]        bin_real;
  logic        [BIN_W-1:0]        bin_imag;

  modport source (output valid, output level_real, output level_imag,
                  output bin_real, output bin_imag, input ready);
  modport sink   (input valid, input level_real, input level_imag,
                  input bin_real, input bin_imag, output ready);
endinterface

FILE: rtl/csq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantizer lane
// Pipelined quantizer for one part of the sample: offset, range clip,
// restoring division by the step (one quotient bit per stage), midpoint.
// ----------------------------------------------------------------------------
module csq_lane #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int MAX_LEVEL_BITS = 8
) (
  input  logic                                clk,
  input  logic [MAX_LEVEL_BITS+3:0]           en,
  input  logic signed [SAMPLE_WIDTH-1:0]      x,
  input  logic signed [SAMPLE_WIDTH-1:0]      lo,
  input  logic [SAMPLE_WIDTH-1:0]             step,
  input  logic [$clog2(MAX_LEVEL_BITS+1)-1:0] k,
  input  logic                                degen,
  output logic signed [SAMPLE_WIDTH-1:0]      level,
  output logic [csq_pkg::BIN_W-1:0]           bin
);
  import csq_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int M  = MAX_LEVEL_BITS;
  localparam int KW = $clog2(MAX_LEVEL_BITS + 1);
  localparam int DW = W + M;
  localparam int NS = M + 3;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] lo;
    logic [W-1:0]        step;
    logic [KW-1:0]       k;
    logic                degen;
    logic                sat;
    logic [W-1:0]        rem;
    logic [M-1:0]        q;
  } lane_stage_t;

  lane_stage_t       stg_r   [NS];
  lane_stage_t       stg_nxt [NS];

  logic [DW-1:0]     prod_r, prod_nxt;
  logic [M-1:0]      bsel_r, bsel_nxt;
  logic signed [W-1:0] lo_r, lo_nxt;
  logic [W-1:0]      step_r, step_nxt;
  logic              degen_r, degen_nxt;

  logic [W:0]        dm1;
  logic [DW-1:0]     lim;
  logic [DW-1:0]     trial [M];
  logic [M:0]        top_ext;
  logic [M-1:0]      top;
  logic [DW:0]       mid;
  logic [BIN_W+M-1:0] bin_ext;

  always_comb begin
    // Stage 0: capture the sample and the decoded range.
    stg_nxt[0]       = '0;
    stg_nxt[0].x     = x;
    stg_nxt[0].lo    = lo;
    stg_nxt[0].step  = step;
    stg_nxt[0].k     = k;
    stg_nxt[0].degen = degen;

    // Stage 1: x - lo - 1; anything at or below the lower limit becomes zero.
    stg_nxt[1] = stg_r[0];
    dm1 = {stg_r[0].x[W-1], stg_r[0].x} + ~{stg_r[0].lo[W-1], stg_r[0].lo};
    stg_nxt[1].rem = dm1[W] ? '0 : dm1[W-1:0];

    // Stage 2: a quotient of 2^k or more saturates to the top bin.
    stg_nxt[2] = stg_r[1];
    lim = DW'(stg_r[1].step) << stg_r[1].k;
    stg_nxt[2].sat = (DW'(stg_r[1].rem) >= lim);

    // Division stages, most significant quotient bit first.
    for (int j = 0; j < M; j++) begin
      trial[j] = DW'(stg_r[2+j].step) << (M - 1 - j);
      stg_nxt[3+j] = stg_r[2+j];
      if (DW'(stg_r[2+j].rem) >= trial[j]) begin
        stg_nxt[3+j].rem         = stg_r[2+j].rem - trial[j][W-1:0];
        stg_nxt[3+j].q[M-1-j]    = 1'b1;
      end
    end

    // Multiply stage: bin times step.
    top_ext   = ({{M{1'b0}}, 1'b1} << stg_r[NS-1].k) - 1'b1;
    top       = top_ext[M-1:0];
    bsel_nxt  = stg_r[NS-1].sat ? top : stg_r[NS-1].q;
    prod_nxt  = DW'(bsel_nxt) * DW'(stg_r[NS-1].step);
    lo_nxt    = stg_r[NS-1].lo;
    step_nxt  = stg_r[NS-1].step;
    degen_nxt = stg_r[NS-1].degen;
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (en[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
    if (en[NS]) begin
      prod_r  <= prod_nxt;
      bsel_r  <= bsel_nxt;
      lo_r    <= lo_nxt;
      step_r  <= step_nxt;
      degen_r <= degen_nxt;
    end
  end

  // Midpoint of the chosen bin: lo + bin*step + step/2.
  assign mid     = {{(DW + 1 - W){lo_r[W-1]}}, lo_r} + {1'b0, prod_r}
                 + (DW + 1)'(step_r >> 1);
  assign bin_ext = {{BIN_W{1'b0}}, bsel_r};
  assign level   = degen_r ? lo_r : mid[W-1:0];
  assign bin     = degen_r ? '0 : bin_ext[BIN_W-1:0];

endmodule

FILE: rtl/csq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipeline flow control
// Per-stage valid bits; a stage advances when it is empty or its successor
// advances, so bubbles collapse and a stalled result holds the rest back.
// ----------------------------------------------------------------------------
module csq_ctrl #(
  parameter int NSTG = 13
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output logic [NSTG-1:0] en
);
  logic [NSTG-1:0] valid_r, valid_nxt;

  always_comb begin
    en[NSTG-1] = !valid_r[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !valid_r[s] || en[s+1];
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int s = 1; s < NSTG; s++) begin
      valid_nxt[s] = en[s] ? valid_r[s-1] : valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid_r[NSTG-1];

endmodule

FILE: rtl/complex_sample_uniform_quantizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex sample uniform quantizer
// Mid-rise quantizer with clipping applied to the real and imaginary parts
// of each sample in two parallel lanes; results merge into one register.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_chan   sink       valid/ready           sample_real, sample_imag
//   out_chan  source     valid/ready           level_real, level_imag,
//                                              bin_real, bin_imag
//   cfg_*     sink       cfg_we (no wait)      cfg_index, cfg_wdata
//
// One transaction is accepted per clock when the output side keeps up. The
// pipeline is MAX_LEVEL_BITS + 5 registers deep, the last being the output
// register that drives out_chan. The depth is set by the restoring divider
// in each lane, which resolves one quotient bit per stage. Reset (rst_n low
// at a clock edge) empties the pipeline and loads the register reset values.
// A stall on out_chan holds the output register; stages behind it keep
// filling bubbles, so in_chan stays ready until the whole pipeline is full.
//
// Each lane subtracts the lower limit, checks whether the quotient would
// reach 2^k (which clips to the top bin), divides by the step and then
// rebuilds the bin midpoint with one multiply and an add.
// ----------------------------------------------------------------------------
module complex_sample_uniform_quantizer_unit #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int MAX_LEVEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  csq_in_if.sink                         in_chan,
  csq_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [csq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]        cfg_wdata
);
  import csq_pkg::*;

  localparam int W    = SAMPLE_WIDTH;
  localparam int M    = MAX_LEVEL_BITS;
  localparam int KW   = $clog2(MAX_LEVEL_BITS + 1);
  localparam int NSTG = M + 5;

  // Configuration registers.
  logic [LEVEL_BITS_W-1:0] level_bits_r, level_bits_nxt;
  logic signed [W-1:0]     upper_r, upper_nxt;
  logic signed [W-1:0]     lower_r, lower_nxt;

  // Decoded range shared by both lanes.
  logic [W:0]              span;
  logic                    hi_le_lo;
  logic [KW-1:0]           k_eff;
  logic [W-1:0]            step;
  logic                    degen;

  // Flow control.
  logic [NSTG-1:0]         en;
  logic                    out_valid;

  // Lane results and the merged output register.
  logic signed [W-1:0]     lane_level_re, lane_level_im;
  logic [BIN_W-1:0]        lane_bin_re, lane_bin_im;
  logic signed [W-1:0]     level_real_r, level_imag_r;
  logic [BIN_W-1:0]        bin_real_r, bin_imag_r;

  always_comb begin
    level_bits_nxt = level_bits_r;
    upper_nxt      = upper_r;
    lower_nxt      = lower_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_BITS:  level_bits_nxt = cfg_wdata[LEVEL_BITS_W-1:0];
        CFG_UPPER_LIMIT: upper_nxt      = cfg_wdata;
        CFG_LOWER_LIMIT: lower_nxt      = cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_bits_r <= LEVEL_BITS_W'(LEVEL_BITS_RESET);
      upper_r      <= W'(UPPER_LIMIT_RESET);
      lower_r      <= W'(LOWER_LIMIT_RESET);
    end else begin
      level_bits_r <= level_bits_nxt;
      upper_r      <= upper_nxt;
      lower_r      <= lower_nxt;
    end
  end

  // Range decode. A zero level-bits setting acts as one, and settings above
  // the supported maximum saturate. An empty range or a zero step makes both
  // parts report the lower limit in bin zero.
  always_comb begin
    span     = {upper_r[W-1], upper_r} - {lower_r[W-1], lower_r};
    hi_le_lo = span[W] || (span == '0);
    if (level_bits_r == '0) begin
      k_eff = KW'(1);
    end else if ({1'b0, level_bits_r} > (LEVEL_BITS_W + 1)'(M)) begin
      k_eff = KW'(M);
    end else begin
      k_eff = KW'(level_bits_r);
    end
    step  = span[W-1:0] >> k_eff;
    degen = hi_le_lo || (step == '0);
  end

  csq_ctrl #(
    .NSTG (NSTG)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .in_ready  (in_chan.ready),
    .out_valid (out_valid),
    .en        (en)
  );

  csq_lane #(
    .SAMPLE_WIDTH   (W),
    .MAX_LEVEL_BITS (M)
  ) u_lane_re (
    .clk   (clk),
    .en    (en[NSTG-2:0]),
    .x     (in_chan.sample_real),
    .lo    (lower_r),
    .step  (step),
    .k     (k_eff),
    .degen (degen),
    .level (lane_level_re),
    .bin   (lane_bin_re)
  );

  csq_lane #(
    .SAMPLE_WIDTH   (W),
    .MAX_LEVEL_BITS (M)
  ) u_lane_im (
    .clk   (clk),
    .en    (en[NSTG-2:0]),
    .x     (in_chan.sample_imag),
    .lo    (lower_r),
    .step  (step),
    .k     (k_eff),
    .degen (degen),
    .level (lane_level_im),
    .bin   (lane_bin_im)
  );

  // Merge stage: both lanes land in the output register together.
  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      level_real_r <= lane_level_re;
      level_imag_r <= lane_level_im;
      bin_real_r   <= lane_bin_re;
      bin_imag_r   <= lane_bin_im;
    end
  end

  assign out_chan.valid      = out_valid;
  assign out_chan.level_real = level_real_r;
  assign out_chan.level_imag = level_imag_r;
  assign out_chan.bin_real   = bin_real_r;
  assign out_chan.bin_imag   = bin_imag_r;

endmodule
